// ===== rtl/dnsaae_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor package
// Shared types and constants for the parser, the result queue and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsaae_pkg;

  localparam int unsigned QuestionNameBytes = 256;
  localparam int unsigned HostNameBytes     = 256;
  localparam int unsigned MaxPacketBytes    = 4096;

  localparam logic [15:0] ServerPortReset = 16'd53;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhIpHdr  = 4'd1;
  localparam logic [3:0] PhUdp    = 4'd2;
  localparam logic [3:0] PhDnsHdr = 4'd3;
  localparam logic [3:0] PhQLen   = 4'd4;
  localparam logic [3:0] PhQLabel = 4'd5;
  localparam logic [3:0] PhQTail  = 4'd6;
  localparam logic [3:0] PhAStart = 4'd7;
  localparam logic [3:0] PhAName  = 4'd8;
  localparam logic [3:0] PhALabel = 4'd9;
  localparam logic [3:0] PhAPtr   = 4'd10;
  localparam logic [3:0] PhAFixed = 4'd11;
  localparam logic [3:0] PhAData  = 4'd12;
  localparam logic [3:0] PhASkip  = 4'd13;

  localparam logic [1:0] KindChar = 2'd0;
  localparam logic [1:0] KindIpv4 = 2'd1;
  localparam logic [1:0] KindIpv6 = 2'd2;

  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [7:0]  PtrMask    = 8'hc0;
  localparam logic [15:0] TypeA      = 16'd1;
  localparam logic [15:0] TypeAaaa   = 16'd28;
  localparam logic [15:0] ClassIn    = 16'd1;
  localparam logic [7:0]  DotChar    = 8'h2e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [62:0] stamp;
    logic [7:0]  host_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dnsaae_parser.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor parser
// Byte-serial packet parser: one accepted byte per cycle, at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsaae_parser #(
  parameter int unsigned QuestionNameBytes = dnsaae_pkg::QuestionNameBytes,
  parameter int unsigned HostNameBytes     = dnsaae_pkg::HostNameBytes,
  parameter int unsigned MaxPacketBytes    = dnsaae_pkg::MaxPacketBytes
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   take_i,
  input  wire [7:0]             data_byte_i,
  input  wire                   first_byte_i,
  input  wire [12:0]            packet_length_i,
  input  wire [62:0]            time_now_i,
  input  wire [15:0]            server_port_i,
  output logic                  res_valid_o,
  output dnsaae_pkg::result_t   res_o
);

  localparam logic [7:0]  QLimit = 8'(QuestionNameBytes - 1);
  localparam logic [7:0]  HLimit = 8'(HostNameBytes - 1);
  localparam logic [12:0] PktMax = 13'(MaxPacketBytes);

  logic [12:0]  off_q, off_d, len_q, len_d;
  logic [5:0]   ihl_q, ihl_d;
  logic [3:0]   ph_q, ph_d;
  logic [15:0]  hw_q, hw_d, ans_q, ans_d;
  logic [7:0]   lab_q, lab_d, nc_q, nc_d;
  logic [15:0]  rt_q, rt_d, rc_q, rc_d, dl_q, dl_d;
  logic [127:0] acc_q, acc_d;

  logic [12:0] rel;
  logic [5:0]  ihl_new;
  logic [7:0]  b;
  logic        run;

  always_comb begin
    off_d = off_q; len_d = len_q; ihl_d = ihl_q; ph_d = ph_q; hw_d = hw_q;
    ans_d = ans_q; lab_d = lab_q; nc_d = nc_q; rt_d = rt_q; rc_d = rc_q;
    dl_d = dl_q; acc_d = acc_q;
    res_valid_o = 1'b0;
    res_o = '0;
    rel = '0;
    ihl_new = '0;
    b = data_byte_i;
    run = 1'b0;
    if (take_i) begin
      if (first_byte_i) begin
        off_d = '0; ihl_d = '0; hw_d = '0; ans_d = '0; lab_d = '0; nc_d = '0;
        rt_d = '0; rc_d = '0; dl_d = '0; acc_d = '0;
        len_d = (packet_length_i > PktMax) ? PktMax : packet_length_i;
        ph_d = dnsaae_pkg::PhIpHdr;
        run = 1'b1;
      end else if (ph_q != dnsaae_pkg::PhIdle) begin
        run = 1'b1;
      end
    end
    if (run) begin
      if (off_d >= len_d) begin
        ph_d = dnsaae_pkg::PhIdle;
      end else begin
        case (ph_d)
          dnsaae_pkg::PhIpHdr: begin
            if (off_d == 13'd0) begin
              ihl_new = {b[3:0], 2'b00};
              if (b[7:4] != 4'd4 || ihl_new < 6'd20 ||
                  len_d < 13'({1'b0, ihl_new} + 7'd20)) begin
                ph_d = dnsaae_pkg::PhIdle;
              end else begin
                ihl_d = ihl_new;
              end
            end
            if (ph_d != dnsaae_pkg::PhIdle) begin
              if (off_d == 13'd9 && b != dnsaae_pkg::ProtoUdp) begin
                ph_d = dnsaae_pkg::PhIdle;
              end else if (off_d + 13'd1 == 13'(ihl_d)) begin
                ph_d = dnsaae_pkg::PhUdp;
              end
            end
          end
          dnsaae_pkg::PhUdp: begin
            rel = off_d - 13'(ihl_d);
            if (rel == 13'd0) begin
              hw_d = {b, 8'h00};
            end else if (rel == 13'd1) begin
              hw_d = hw_q | 16'(b);
              if ((hw_q | 16'(b)) != server_port_i) ph_d = dnsaae_pkg::PhIdle;
            end else if (rel == 13'd7) begin
              ph_d = dnsaae_pkg::PhDnsHdr;
            end
          end
          dnsaae_pkg::PhDnsHdr: begin
            rel = off_d - 13'(ihl_d) - 13'd8;
            if (rel == 13'd2 && !b[7]) begin
              ph_d = dnsaae_pkg::PhIdle;
            end else if (rel == 13'd6) begin
              hw_d = {b, 8'h00};
            end else if (rel == 13'd7) begin
              ans_d = hw_q | 16'(b);
            end else if (rel == 13'd11) begin
              ph_d = (ans_q != 16'd0) ? dnsaae_pkg::PhQLen : dnsaae_pkg::PhIdle;
            end
          end
          dnsaae_pkg::PhQLen: begin
            if (b == 8'd0 || (b & dnsaae_pkg::PtrMask) != 8'd0) begin
              if (nc_q == 8'd0) begin
                ph_d = dnsaae_pkg::PhIdle;
              end else begin
                lab_d = (b == 8'd0) ? 8'd4 : 8'd5;
                ph_d = dnsaae_pkg::PhQTail;
              end
            end else if ({1'b0, off_d} + 14'(b) >= {1'b0, len_d}) begin
              ph_d = dnsaae_pkg::PhIdle;
            end else begin
              lab_d = b;
              ph_d = dnsaae_pkg::PhQLabel;
              if (nc_q != 8'd0 && nc_q < QLimit) begin
                nc_d = nc_q + 8'd1;
                res_valid_o = 1'b1;
                res_o.kind = dnsaae_pkg::KindChar;
                res_o.name_char = dnsaae_pkg::DotChar;
              end
            end
          end
          dnsaae_pkg::PhQLabel: begin
            lab_d = lab_q - 8'd1;
            if (lab_d == 8'd0) ph_d = dnsaae_pkg::PhQLen;
            if (nc_q < QLimit) begin
              nc_d = nc_q + 8'd1;
              res_valid_o = 1'b1;
              res_o.kind = dnsaae_pkg::KindChar;
              res_o.name_char = b;
            end
          end
          dnsaae_pkg::PhQTail: begin
            lab_d = lab_q - 8'd1;
            if (lab_d == 8'd0) ph_d = dnsaae_pkg::PhAStart;
          end
          dnsaae_pkg::PhAStart, dnsaae_pkg::PhAName: begin
            if (ph_d == dnsaae_pkg::PhAStart &&
                (ans_q == 16'd0 || {1'b0, off_d} + 14'd10 >= {1'b0, len_d})) begin
              ph_d = dnsaae_pkg::PhIdle;
            end else begin
              if (ph_d == dnsaae_pkg::PhAStart) ans_d = ans_q - 16'd1;
              if (b == 8'd0) begin
                lab_d = '0;
                ph_d = dnsaae_pkg::PhAFixed;
              end else if ((b & dnsaae_pkg::PtrMask) != 8'd0) begin
                ph_d = dnsaae_pkg::PhAPtr;
              end else if ({1'b0, off_d} + 14'(b) + 14'd1 >= {1'b0, len_d}) begin
                ph_d = dnsaae_pkg::PhIdle;
              end else begin
                lab_d = b;
                ph_d = dnsaae_pkg::PhALabel;
              end
            end
          end
          dnsaae_pkg::PhALabel: begin
            lab_d = lab_q - 8'd1;
            if (lab_d == 8'd0) ph_d = dnsaae_pkg::PhAName;
          end
          dnsaae_pkg::PhAPtr: begin
            lab_d = '0;
            ph_d = dnsaae_pkg::PhAFixed;
          end
          dnsaae_pkg::PhAFixed: begin
            if (lab_q == 8'd0 && {1'b0, off_d} + 14'd10 >= {1'b0, len_d}) begin
              ph_d = dnsaae_pkg::PhIdle;
            end else begin
              case (lab_q)
                8'd0, 8'd2, 8'd8: hw_d = {b, 8'h00};
                8'd1: rt_d = hw_q | 16'(b);
                8'd3: rc_d = hw_q | 16'(b);
                8'd9: dl_d = hw_q | 16'(b);
                default: ;
              endcase
              lab_d = lab_q + 8'd1;
              if (lab_d == 8'd10) begin
                if (dl_d == 16'd0) begin
                  ph_d = dnsaae_pkg::PhAStart;
                end else if (rc_d == dnsaae_pkg::ClassIn &&
                             ((rt_d == dnsaae_pkg::TypeA && dl_d == 16'd4) ||
                              (rt_d == dnsaae_pkg::TypeAaaa && dl_d == 16'd16))) begin
                  acc_d = '0;
                  ph_d = dnsaae_pkg::PhAData;
                end else begin
                  ph_d = dnsaae_pkg::PhASkip;
                end
              end
            end
          end
          dnsaae_pkg::PhAData: begin
            acc_d = {acc_q[119:0], b};
            dl_d = dl_q - 16'd1;
            if (dl_d == 16'd0) begin
              ph_d = dnsaae_pkg::PhAStart;
              res_valid_o = 1'b1;
              res_o.kind = (rt_q == dnsaae_pkg::TypeA) ? dnsaae_pkg::KindIpv4
                                                       : dnsaae_pkg::KindIpv6;
              res_o.address_high = acc_d[127:64];
              res_o.address_low = acc_d[63:0];
              res_o.stamp = time_now_i;
              res_o.host_length = (nc_q < HLimit) ? nc_q : HLimit;
            end
          end
          dnsaae_pkg::PhASkip: begin
            dl_d = dl_q - 16'd1;
            if (dl_d == 16'd0) ph_d = dnsaae_pkg::PhAStart;
          end
          default: begin
            ph_d = dnsaae_pkg::PhIdle;
          end
        endcase
        if (off_d < 13'h1fff) off_d = off_d + 13'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; len_q <= '0; ihl_q <= '0; ph_q <= dnsaae_pkg::PhIdle;
      hw_q <= '0; ans_q <= '0; lab_q <= '0; nc_q <= '0; rt_q <= '0;
      rc_q <= '0; dl_q <= '0; acc_q <= '0;
    end else begin
      off_q <= off_d; len_q <= len_d; ihl_q <= ihl_d; ph_q <= ph_d;
      hw_q <= hw_d; ans_q <= ans_d; lab_q <= lab_d; nc_q <= nc_d; rt_q <= rt_d;
      rc_q <= rc_d; dl_q <= dl_d; acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dnsaae_queue.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor result queue
// Small register queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsaae_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wr_i,
  input  dnsaae_pkg::result_t   wr_data_i,
  input  wire                   rd_i,
  output dnsaae_pkg::result_t   rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned Depth = dnsaae_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  dnsaae_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW + 1)'(do_wr) - (PtrW + 1)'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dns_answer_address_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor
// Parses captured IPv4/UDP DNS responses and reports question names and
// A/AAAA answer addresses.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle while full is low, with no gaps
// between packets. Each byte yields at most one result: a question-name
// character, or an address mapping on the last data byte of an A or AAAA
// answer. Results pass through a two-entry queue, so input stalls (full
// high) only when that queue is full. The source port is written through
// the cfg channel, which is always ready.
`default_nettype none

module dns_answer_address_extractor_unit #(
  parameter int unsigned QuestionNameBytes = dnsaae_pkg::QuestionNameBytes,
  parameter int unsigned HostNameBytes     = dnsaae_pkg::HostNameBytes,
  parameter int unsigned MaxPacketBytes    = dnsaae_pkg::MaxPacketBytes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire [7:0]   data_byte_i,
  input  wire         first_byte_i,
  input  wire [12:0]  packet_length_i,
  input  wire [62:0]  time_now_i,
  output logic        empty,
  input  wire         pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_char_o,
  output logic [63:0] address_high_o,
  output logic [63:0] address_low_o,
  output logic [62:0] stamp_o,
  output logic [7:0]  host_length_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [15:0]  cfg_data_i
);

  logic [15:0] port_q;
  logic        res_valid;
  dnsaae_pkg::result_t res, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= dnsaae_pkg::ServerPortReset;
    end else if (cfg_valid_i) begin
      port_q <= cfg_data_i;
    end
  end

  dnsaae_parser #(
    .QuestionNameBytes(QuestionNameBytes),
    .HostNameBytes(HostNameBytes),
    .MaxPacketBytes(MaxPacketBytes)
  ) u_parser (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .take_i(push && !full),
    .data_byte_i(data_byte_i),
    .first_byte_i(first_byte_i),
    .packet_length_i(packet_length_i),
    .time_now_i(time_now_i),
    .server_port_i(port_q),
    .res_valid_o(res_valid),
    .res_o(res)
  );

  dnsaae_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .wr_i(res_valid),
    .wr_data_i(res),
    .rd_i(pop),
    .rd_data_o(head),
    .full_o(full),
    .empty_o(empty)
  );

  assign kind_o         = head.kind;
  assign name_char_o    = head.name_char;
  assign address_high_o = head.address_high;
  assign address_low_o  = head.address_low;
  assign stamp_o        = head.stamp;
  assign host_length_o  = head.host_length;

endmodule

`default_nettype wire

// ===== dv/tb_dns_answer_address_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor testbench
// Sends captured IPv4 packets byte by byte, mostly well-formed DNS responses
// with random names and answers, plus broken and dropped packets. An
// in-bench parser predicts each name character and address mapping, and
// every popped result is compared field by field. Sender and receiver
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dns_answer_address_extractor_unit;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic [12:0] packet_length_i;
  logic [62:0] time_now_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [7:0]  name_char_o;
  logic [63:0] address_high_o;
  logic [63:0] address_low_o;
  logic [62:0] stamp_o;
  logic [7:0]  host_length_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  dns_answer_address_extractor_unit u_top (
    .clk_i, .rst_ni, .push, .full, .data_byte_i, .first_byte_i,
    .packet_length_i, .time_now_i, .empty, .pop, .kind_o, .name_char_o,
    .address_high_o, .address_low_o, .stamp_o, .host_length_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser model state
  int unsigned srv_port, off, plen_q, ihl_q, hword, ans_left, lab_left, name_cnt;
  int unsigned rec_type, rec_class, dlen;
  logic [3:0]  phase;
  logic [63:0] acc_hi, acc_lo;

  dnsaae_pkg::result_t pending_results[$];
  logic [7:0]  frame[$];
  int unsigned failures = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  longint unsigned cycles = 0;

  function automatic void clear_packet();
    off = 0; plen_q = 0; ihl_q = 0; phase = dnsaae_pkg::PhIdle; hword = 0;
    ans_left = 0; lab_left = 0; name_cnt = 0; rec_type = 0; rec_class = 0; dlen = 0;
    acc_hi = '0; acc_lo = '0;
  endfunction

  function automatic void answer_name(logic [7:0] b, int unsigned pos);
    if (b == 8'd0) begin
      lab_left = 0; phase = dnsaae_pkg::PhAFixed;
    end else if ((b & dnsaae_pkg::PtrMask) != 0) begin
      phase = dnsaae_pkg::PhAPtr;
    end else if (pos + b + 1 >= plen_q) begin
      phase = dnsaae_pkg::PhIdle;
    end else begin
      lab_left = b; phase = dnsaae_pkg::PhALabel;
    end
  endfunction

  function automatic void add_char(logic [7:0] c);
    dnsaae_pkg::result_t r;
    r = '0;
    r.kind = dnsaae_pkg::KindChar;
    r.name_char = c;
    pending_results.push_back(r);
  endfunction

  function automatic void track_dns_byte(logic [7:0] b, logic first, logic [12:0] plen,
                                         logic [62:0] now);
    int unsigned pos, rel, ihl;
    dnsaae_pkg::result_t r;
    if (first) begin
      clear_packet();
      plen_q = plen > dnsaae_pkg::MaxPacketBytes ? dnsaae_pkg::MaxPacketBytes : plen;
      phase = dnsaae_pkg::PhIpHdr;
    end else if (phase == dnsaae_pkg::PhIdle) begin
      return;
    end
    if (off >= plen_q) begin
      phase = dnsaae_pkg::PhIdle;
      return;
    end
    pos = off;
    case (phase)
      dnsaae_pkg::PhIpHdr: begin
        if (pos == 0) begin
          ihl = b[3:0] * 4;
          if (b[7:4] != 4'd4 || ihl < 20 || plen_q < ihl + 20) phase = dnsaae_pkg::PhIdle;
          else ihl_q = ihl;
        end
        if (phase != dnsaae_pkg::PhIdle) begin
          if (pos == 9 && b != dnsaae_pkg::ProtoUdp) phase = dnsaae_pkg::PhIdle;
          else if (pos + 1 == ihl_q) phase = dnsaae_pkg::PhUdp;
        end
      end
      dnsaae_pkg::PhUdp: begin
        rel = pos - ihl_q;
        if (rel == 0) hword = b << 8;
        else if (rel == 1) begin
          hword = (hword | b) & 16'hffff;
          if (hword != srv_port) phase = dnsaae_pkg::PhIdle;
        end else if (rel == 7) phase = dnsaae_pkg::PhDnsHdr;
      end
      dnsaae_pkg::PhDnsHdr: begin
        rel = pos - ihl_q - 8;
        if (rel == 2 && !b[7]) phase = dnsaae_pkg::PhIdle;
        else if (rel == 6) hword = b << 8;
        else if (rel == 7) ans_left = (hword | b) & 16'hffff;
        else if (rel == 11) phase = ans_left != 0 ? dnsaae_pkg::PhQLen : dnsaae_pkg::PhIdle;
      end
      dnsaae_pkg::PhQLen: begin
        if (b == 0 || (b & dnsaae_pkg::PtrMask) != 0) begin
          if (name_cnt == 0) phase = dnsaae_pkg::PhIdle;
          else begin
            lab_left = b == 0 ? 4 : 5;
            phase = dnsaae_pkg::PhQTail;
          end
        end else if (pos + b >= plen_q) begin
          phase = dnsaae_pkg::PhIdle;
        end else begin
          lab_left = b;
          phase = dnsaae_pkg::PhQLabel;
          if (name_cnt > 0 && name_cnt < dnsaae_pkg::QuestionNameBytes - 1) begin
            name_cnt++;
            add_char(dnsaae_pkg::DotChar);
          end
        end
      end
      dnsaae_pkg::PhQLabel: begin
        lab_left--;
        if (lab_left == 0) phase = dnsaae_pkg::PhQLen;
        if (name_cnt < dnsaae_pkg::QuestionNameBytes - 1) begin
          name_cnt++;
          add_char(b);
        end
      end
      dnsaae_pkg::PhQTail: begin
        lab_left--;
        if (lab_left == 0) phase = dnsaae_pkg::PhAStart;
      end
      dnsaae_pkg::PhAStart: begin
        if (ans_left == 0 || pos + 10 >= plen_q) phase = dnsaae_pkg::PhIdle;
        else begin
          ans_left--;
          answer_name(b, pos);
        end
      end
      dnsaae_pkg::PhAName: answer_name(b, pos);
      dnsaae_pkg::PhALabel: begin
        lab_left--;
        if (lab_left == 0) phase = dnsaae_pkg::PhAName;
      end
      dnsaae_pkg::PhAPtr: begin
        lab_left = 0;
        phase = dnsaae_pkg::PhAFixed;
      end
      dnsaae_pkg::PhAFixed: begin
        if (lab_left == 0 && pos + 10 >= plen_q) phase = dnsaae_pkg::PhIdle;
        else begin
          case (lab_left)
            0, 2, 8: hword = b << 8;
            1: rec_type = (hword | b) & 16'hffff;
            3: rec_class = (hword | b) & 16'hffff;
            9: dlen = (hword | b) & 16'hffff;
            default: ;
          endcase
          lab_left++;
          if (lab_left == 10) begin
            if (dlen == 0) phase = dnsaae_pkg::PhAStart;
            else if (rec_class == dnsaae_pkg::ClassIn &&
                     ((rec_type == dnsaae_pkg::TypeA && dlen == 4) ||
                      (rec_type == dnsaae_pkg::TypeAaaa && dlen == 16))) begin
              acc_hi = '0; acc_lo = '0;
              phase = dnsaae_pkg::PhAData;
            end else phase = dnsaae_pkg::PhASkip;
          end
        end
      end
      dnsaae_pkg::PhAData: begin
        acc_hi = {acc_hi[55:0], acc_lo[63:56]};
        acc_lo = {acc_lo[55:0], b};
        dlen--;
        if (dlen == 0) begin
          phase = dnsaae_pkg::PhAStart;
          r = '0;
          r.kind = rec_type == dnsaae_pkg::TypeA ? dnsaae_pkg::KindIpv4
                                                 : dnsaae_pkg::KindIpv6;
          r.address_high = acc_hi;
          r.address_low = acc_lo;
          r.stamp = now;
          r.host_length = 8'(name_cnt < dnsaae_pkg::HostNameBytes - 1 ? name_cnt
                                                                      : dnsaae_pkg::HostNameBytes - 1);
          pending_results.push_back(r);
        end
      end
      dnsaae_pkg::PhASkip: begin
        dlen--;
        if (dlen == 0) phase = dnsaae_pkg::PhAStart;
      end
      default: phase = dnsaae_pkg::PhIdle;
    endcase
    if (off < 13'h1fff) off++;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_byte(logic [7:0] b, logic first, logic [12:0] plen);
    logic [62:0] now;
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    now = 63'({$urandom, $urandom});
    push <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= first;
    packet_length_i <= plen;
    time_now_i <= now;
    do @(posedge clk_i); while (full);
    track_dns_byte(b, first, plen, now);
    bytes_sent++;
  endtask

  task automatic send_frame(int unsigned plen);
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == 0, plen[12:0]);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_port(logic [15:0] port);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= port;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    srv_port = port;
  endtask

  // ------------------------------------------------------------- frame build
  function automatic void put16(int unsigned v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endfunction

  function automatic void put_rand(int unsigned n);
    repeat (n) frame.push_back(8'($urandom));
  endfunction

  function automatic void build_response(int unsigned port, int unsigned n_ans,
                                         int unsigned n_labels, bit long_labels);
    int unsigned ihl, len, k, dl, ty;
    frame.delete();
    ihl = $urandom_range(5, 7);
    frame.push_back({4'd4, ihl[3:0]});
    for (int i = 1; i < ihl * 4; i++) begin
      frame.push_back(i == 9 ? dnsaae_pkg::ProtoUdp : 8'($urandom));
    end
    put16(port);
    put_rand(6);
    put_rand(2);
    frame.push_back({1'b1, 7'($urandom)});
    put_rand(3);
    put16(n_ans);
    put_rand(4);
    repeat (n_labels) begin
      len = long_labels ? 63 : $urandom_range(1, 8);
      frame.push_back(8'(len));
      put_rand(len);
    end
    if ($urandom_range(0, 3) == 0) begin
      frame.push_back(8'($urandom_range(64, 255)));
      put_rand(1);
    end else frame.push_back(8'd0);
    put_rand(4);
    repeat (n_ans) begin
      k = $urandom_range(0, 2);
      if (k != 0) begin
        repeat ($urandom_range(1, 2)) begin
          len = $urandom_range(1, 4);
          frame.push_back(8'(len));
          put_rand(len);
        end
      end
      if (k == 1) frame.push_back(8'd0);
      else begin
        frame.push_back(8'($urandom_range(64, 255)));
        put_rand(1);
      end
      k = $urandom_range(0, 6);
      case (k)
        0, 1: begin ty = dnsaae_pkg::TypeA; dl = 4; end
        2, 3: begin ty = dnsaae_pkg::TypeAaaa; dl = 16; end
        4: begin ty = $urandom_range(0, 65535); dl = $urandom_range(0, 6); end
        5: begin ty = dnsaae_pkg::TypeA; dl = $urandom_range(0, 1) ? 0 : 16; end
        default: begin ty = dnsaae_pkg::TypeAaaa; dl = 16; end
      endcase
      put16(ty);
      put16(k == 6 ? $urandom_range(0, 65535) : dnsaae_pkg::ClassIn);
      put_rand(4);
      put16(dl);
      put_rand(dl);
    end
  endfunction

  // ------------------------------------------------------------------ tests
  task automatic test_noise_before_packet();
    repeat (3) send_byte(8'($urandom), 1'b0, 13'($urandom));
  endtask

  task automatic test_basic_responses();
    build_response(srv_port, 2, 2, 0);
    send_frame(frame.size());
    build_response(srv_port, 2, 1, 0);
    send_frame(frame.size());
  endtask

  task automatic test_drop_cases();
    build_response(srv_port, 1, 1, 0);
    frame[0] = 8'h65;  // wrong version
    send_frame(frame.size());
    frame[0] = 8'h44;  // header below five words
    send_frame(frame.size());
    frame[0] = 8'h45;
    send_frame(20);    // too short for the headers
    send_frame(13'h1fff);  // clamped, more than what is sent
    frame[9] = 8'd6;   // not UDP
    send_frame(frame.size());
    build_response(srv_port, 1, 1, 0);
    frame[frame[0][3:0] * 4 + 1] = frame[frame[0][3:0] * 4 + 1] ^ 8'h01;  // wrong source port
    send_frame(frame.size());
    build_response(srv_port, 0, 1, 0);  // no answers
    send_frame(frame.size());
    build_response(srv_port, 1, 0, 0);  // empty question name
    send_frame(frame.size());
    build_response(srv_port, 1, 1, 0);
    send_frame(frame.size() - 3);  // last record cut off
    for (int i = 0; i < 4; i++) frame.push_back(8'($urandom));
    send_frame(frame.size() - 4);  // bytes past the length
  endtask

  task automatic test_long_name();
    build_response(srv_port, 1, 5, 1);
    send_frame(frame.size());
  endtask

  task automatic test_server_port();
    write_port(16'd0);
    build_response(0, 1, 1, 0);
    send_frame(frame.size());
    write_port(16'hffff);
    build_response(16'hffff, 1, 1, 0);
    send_frame(frame.size());
  endtask

  task automatic test_random_traffic(int unsigned s_idle, int unsigned r_idle);
    int unsigned target, sz, mode;
    write_port($urandom_range(0, 3) == 0 ? 16'($urandom) : dnsaae_pkg::ServerPortReset);
    send_idle = s_idle;
    recv_idle = r_idle;
    target = bytes_sent + 40;
    while (bytes_sent < target) begin
      build_response(srv_port, $urandom_range(1, 3), $urandom_range(0, 8) == 0 ? 0 :
                     $urandom_range(1, 3), 0);
      mode = $urandom_range(0, 99);
      if (mode >= 80) frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      sz = frame.size();
      if (mode < 8) sz = $urandom_range(0, sz);
      else if (mode < 12) sz = $urandom_range(sz, 8191);
      send_frame(sz);
    end
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    dnsaae_pkg::result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: kind %0d", kind_o);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind) begin
          $error("kind: expected %0d, actual %0d", exp_r.kind, kind_o); failures++;
        end
        if (name_char_o !== exp_r.name_char) begin
          $error("name_char: expected %0h, actual %0h", exp_r.name_char, name_char_o);
          failures++;
        end
        if (address_high_o !== exp_r.address_high) begin
          $error("address_high: expected %0h, actual %0h", exp_r.address_high,
                 address_high_o);
          failures++;
        end
        if (address_low_o !== exp_r.address_low) begin
          $error("address_low: expected %0h, actual %0h", exp_r.address_low, address_low_o);
          failures++;
        end
        if (stamp_o !== exp_r.stamp) begin
          $error("stamp: expected %0h, actual %0h", exp_r.stamp, stamp_o); failures++;
        end
        if (host_length_o !== exp_r.host_length) begin
          $error("host_length: expected %0d, actual %0d", exp_r.host_length, host_length_o);
          failures++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    data_byte_i <= '0;
    first_byte_i <= 1'b0;
    packet_length_i <= '0;
    time_now_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    clear_packet();
    srv_port = dnsaae_pkg::ServerPortReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_noise_before_packet();
    test_basic_responses();
    test_drop_cases();
    test_long_name();
    test_server_port();
    test_random_traffic(7, 85);
    test_random_traffic(85, 7);
    test_random_traffic(0, 0);
    drain();
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
